/* rtl/tile_background_pixel_fetch_assert.svh */
// Assertion macros used by the tile background fetch back end.
`ifndef TILE_BACKGROUND_PIXEL_FETCH_ASSERT_SVH
`define TILE_BACKGROUND_PIXEL_FETCH_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TBPF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbpf assertion failed");

// Next-cycle implication, checked outside reset.
`define TBPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbpf assertion failed");

`endif

/* rtl/tbpf_pkg.sv */
// Types and constants of the tile background pixel fetch block.
`default_nettype none

package tbpf_pkg;

  localparam int VRAM_BYTES = 8192;
  localparam int VRAM_AW = $clog2(VRAM_BYTES);
  localparam int SCREEN_WIDTH_DEFAULT = 160;
  localparam int SCREEN_HEIGHT_DEFAULT = 144;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_PALETTE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SELECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_SELECT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_ENABLE = 3'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Tile maps sit in the top 2 KiB: 0x1800 or 0x1C00.
  localparam logic [1:0] MAP_REGION = 2'b11;
  // Signed tile numbers are centered on 0x1000, so tile 0x80 lands at 0x0800.
  localparam logic [VRAM_AW-1:0] SIGNED_BASE = 13'h0800;

  typedef struct packed {
    logic       op;
    logic [12:0] vram_addr;
    logic [7:0] vram_data;
    logic [7:0] pixel_x;
    logic [7:0] screen_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0] shade;
    logic [7:0] out_x;
    logic [7:0] out_line;
  } out_item_t;

  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] bg_palette;
    logic       map_select;
    logic       data_select;
    logic       bg_enable;
  } cfg_t;

  // Work item between front and back: a memory write, or a render with its map address.
  typedef struct packed {
    logic               is_write;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         data;
    logic [2:0]         fine_x;
    logic [2:0]         fine_y;
    logic [7:0]         px;
    logic [7:0]         line;
  } work_t;

endpackage

`default_nettype wire

/* rtl/tile_background_pixel_fetch.sv */
// Top level of the tile background pixel fetch block.
// Usage:
//   Input queue side: drive request and raise push; a transfer happens at a rising
//   edge with push high and full low. op write stores vram_data at vram_addr and
//   gives no result; op render gives one result unless the pixel is off screen.
//   Result queue side: while empty is low, result holds the oldest shade with its
//   column and line; raising pop transfers it.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write registers only while the block is idle.
// Timing:
//   A render passes the work queue and the back-end states idle, tile, low and high
//   before it shows up. The back end reads the single-port video memory three times
//   in a row (map entry, low plane, high plane) and starts a new item only from idle.
//   A 4-entry work queue decouples acceptance from the back end.
// Reset (synchronous, rst high): clears queues, state and registers; the video
//   memory is not cleared and must be written before it is rendered from.
// Stall: with the result waiting, the back end holds in its high-plane state and
//   the work queue keeps filling until full rises.
`default_nettype none

module tile_background_pixel_fetch
  import tbpf_pkg::*;
#(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEFAULT,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire in_item_t             request,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      empty,
  output out_item_t                 result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t  cfg;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  work_t q_item;
  work_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCROLL_X:    cfg.scroll_x <= cfg_data;
        CFG_SCROLL_Y:    cfg.scroll_y <= cfg_data;
        CFG_BG_PALETTE:  cfg.bg_palette <= cfg_data;
        CFG_MAP_SELECT:  cfg.map_select <= cfg_data[0];
        CFG_DATA_SELECT: cfg.data_select <= cfg_data[0];
        CFG_BG_ENABLE:   cfg.bg_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tbpf_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .push   (push),
    .request(request),
    .cfg    (cfg),
    .q_full (q_full),
    .full   (full),
    .q_push (q_push),
    .q_item (q_item)
  );

  tbpf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_item(q_item),
    .rd_en  (q_pop),
    .head   (q_head),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  tbpf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_head (q_head),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

`default_nettype wire

/* rtl/tbpf_front.sv */
// Front end: accepts items, drops off-screen renders, forms the tile map address.
`default_nettype none

module tbpf_front
  import tbpf_pkg::*;
#(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEFAULT,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
  input  wire logic     push,
  input  wire in_item_t request,
  input  wire cfg_t     cfg,
  input  wire logic     q_full,
  output logic          full,
  output logic          q_push,
  output work_t         q_item
);

  logic       accept;
  logic       on_screen;
  logic [7:0] ax;
  logic [7:0] ay;

  assign full = q_full;
  assign accept = push && !q_full;

  assign on_screen = ({1'b0, request.pixel_x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, request.screen_line} < 9'(SCREEN_HEIGHT));

  assign ax = request.pixel_x + cfg.scroll_x;
  assign ay = request.screen_line + cfg.scroll_y;

  assign q_push = accept && ((request.op == OP_WRITE) || on_screen);

  always_comb begin
    q_item.is_write = (request.op == OP_WRITE);
    q_item.data = request.vram_data;
    q_item.fine_x = ax[2:0];
    q_item.fine_y = ay[2:0];
    q_item.px = request.pixel_x;
    q_item.line = request.screen_line;
    if (request.op == OP_WRITE) begin
      q_item.addr = request.vram_addr;
    end else begin
      q_item.addr = {MAP_REGION, cfg.map_select, ay[7:3], ax[7:3]};
    end
  end

endmodule

`default_nettype wire

/* rtl/tbpf_queue.sv */
// Short FIFO of work items between front and back.
`default_nettype none

module tbpf_queue
  import tbpf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire work_t wr_item,
  input  wire logic  rd_en,
  output work_t      head,
  output logic       q_full,
  output logic       q_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  work_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign q_full = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr = wr_en && !q_full;
  assign do_rd = rd_en && !q_empty;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tbpf_back.sv */
// Back end: video memory, the three dependent reads, palette mapping, result register.
`default_nettype none

module tbpf_back
  import tbpf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire work_t q_head,
  input  wire logic  q_empty,
  output logic       q_pop,
  input  wire logic  pop,
  output logic       empty,
  output out_item_t  result
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TILE = 4'b0010,
    S_LO   = 4'b0100,
    S_HI   = 4'b1000
  } state_t;

  logic [7:0]         vram [VRAM_BYTES];
  logic [7:0]         rd_data;
  logic               rd_en;
  logic [VRAM_AW-1:0] rd_addr;
  logic               mem_we;

  state_t             state;
  state_t             state_next;
  work_t              cur;
  logic [VRAM_AW-1:0] row_addr;
  logic [VRAM_AW-1:0] row_calc;
  logic [7:0]         lo_byte;
  logic [1:0]         colour;
  logic [1:0]         pal_shade;

  logic               out_valid;
  out_item_t          out_item;
  logic               slot_free;
  logic               out_load;

  assign empty = !out_valid;
  assign result = out_item;
  assign slot_free = !out_valid || pop;

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign mem_we = q_pop && q_head.is_write;

  // Tile row: unsigned 16*n, or signed around 0x1000.
  always_comb begin
    if (cfg.data_select) begin
      row_calc = {1'b0, rd_data, cur.fine_y, 1'b0};
    end else begin
      row_calc = SIGNED_BASE + {1'b0, rd_data ^ 8'h80, 4'b0000} +
                 {{(VRAM_AW-4){1'b0}}, cur.fine_y, 1'b0};
    end
  end

  assign colour = {rd_data[~cur.fine_x], lo_byte[~cur.fine_x]};
  assign pal_shade = cfg.bg_palette[{colour, 1'b0} +: 2];
  assign out_load = (state == S_HI) && slot_free;

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    rd_addr = q_head.addr;
    unique case (state)
      S_IDLE: begin
        if (q_pop && !q_head.is_write) begin
          rd_en = 1'b1;
          state_next = S_TILE;
        end
      end
      S_TILE: begin
        rd_en = 1'b1;
        rd_addr = row_calc;
        state_next = S_LO;
      end
      S_LO: begin
        rd_en = 1'b1;
        rd_addr = row_addr | VRAM_AW'(1);
        state_next = S_HI;
      end
      S_HI: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vram[q_head.addr] <= q_head.data;
    end
    if (rd_en) begin
      rd_data <= vram[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == S_TILE) begin
      row_addr <= row_calc;
    end
    if (state == S_LO) begin
      lo_byte <= rd_data;
    end
    if (out_load) begin
      out_item.shade <= cfg.bg_enable ? pal_shade : 2'b00;
      out_item.out_x <= cur.px;
      out_item.out_line <= cur.line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "tile_background_pixel_fetch_assert.svh"

  `TBPF_ASSERT_IMPL(a_pop_only_idle, clk, rst, q_pop, state == S_IDLE)
  `TBPF_ASSERT_IMPL(a_write_from_queue, clk, rst, mem_we, !q_empty && q_head.is_write)
  `TBPF_ASSERT_IMPL(a_tile_after_idle, clk, rst, state == S_TILE, $past(state) == S_IDLE)
  `TBPF_ASSERT_NEXT(a_disabled_shade, clk, rst, out_load && !cfg.bg_enable,
                    out_valid && out_item.shade == 2'b00)

endmodule

`default_nettype wire

/* verif/tile_fetch_checker.sv */
// Checker for the tile background pixel fetch: predicts shades and compares results.
`timescale 1ns / 100ps

module tile_fetch_checker
  import tbpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  in_item_t             request,
  input  logic                 pop,
  input  logic                 empty,
  input  out_item_t            result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   mismatches,
  output int                   pixels_owed
);

  localparam logic [12:0] MAP0_BASE = 13'h1800;
  localparam logic [12:0] MAP1_BASE = 13'h1C00;
  localparam logic [12:0] SIGNED_TILE_BASE = 13'h0800;

  logic [7:0] vram_image [0:VRAM_BYTES-1];
  cfg_t       regs;
  out_item_t  pending_pixels [$];
  int         errors;

  initial begin
    mismatches = 0;
    pixels_owed = 0;
  end

  function automatic out_item_t predict_pixel(input logic [7:0] px, input logic [7:0] line);
    logic [7:0]  ax, ay, tile, lo, hi;
    logic [12:0] map_addr, row;
    logic [1:0]  colour;
    int          b;
    out_item_t   r;
    ax = px + regs.scroll_x;
    ay = line + regs.scroll_y;
    map_addr = (regs.map_select ? MAP1_BASE : MAP0_BASE) + {3'd0, ay[7:3], ax[7:3]};
    tile = vram_image[map_addr];
    // unsigned mode indexes from 0; signed mode treats the index as -128..127 around 0x1000
    if (regs.data_select) begin
      row = {1'b0, tile, 4'd0};
    end else begin
      row = SIGNED_TILE_BASE + {1'b0, tile ^ 8'h80, 4'd0};
    end
    row = row + {9'd0, ay[2:0], 1'b0};
    lo = vram_image[row];
    hi = vram_image[row + 13'd1];
    b = 7 - ax[2:0];  // bit 7 is the leftmost pixel
    colour = {hi[b], lo[b]};
    r.shade = regs.bg_enable ? regs.bg_palette[2*colour +: 2] : 2'd0;
    r.out_x = px;
    r.out_line = line;
    return r;
  endfunction

  always @(posedge clk) begin : track
    out_item_t want;
    if (rst) begin
      regs = '0;
      pending_pixels.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCROLL_X: regs.scroll_x = cfg_data;
          CFG_SCROLL_Y: regs.scroll_y = cfg_data;
          CFG_BG_PALETTE: regs.bg_palette = cfg_data;
          CFG_MAP_SELECT: regs.map_select = cfg_data[0];
          CFG_DATA_SELECT: regs.data_select = cfg_data[0];
          CFG_BG_ENABLE: regs.bg_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) begin
        if (request.op == OP_WRITE) begin
          vram_image[request.vram_addr] = request.vram_data;
        end else if (request.pixel_x < SCREEN_WIDTH_DEFAULT &&
                     request.screen_line < SCREEN_HEIGHT_DEFAULT) begin
          pending_pixels.push_back(predict_pixel(request.pixel_x, request.screen_line));
        end
      end
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel result (x %0d, line %0d) with nothing expected",
                 result.out_x, result.out_line);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (result.shade !== want.shade) begin
            $error("shade: expected %0d, got %0d", want.shade, result.shade);
            errors++;
          end
          if (result.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, result.out_x);
            errors++;
          end
          if (result.out_line !== want.out_line) begin
            $error("out_line: expected %0d, got %0d", want.out_line, result.out_line);
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    pixels_owed <= pending_pixels.size();
  end

endmodule

/* verif/tb_tile_background_pixel_fetch.sv */
// Testbench top for the tile background pixel fetch: stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb_tile_background_pixel_fetch;
  import tbpf_pkg::*;

  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 195;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT = 2000;
  localparam logic [12:0] MAP0_BASE = 13'h1800;
  localparam logic [12:0] MAP1_BASE = 13'h1C00;
  localparam logic [12:0] SIGNED_TILE_BASE = 13'h0800;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  in_item_t             request = '0;
  logic                 full;
  logic                 pop = 1'b0;
  logic                 empty;
  out_item_t            result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  int                   mismatches;
  int                   pixels_owed;

  // stimulus-side view of memory, so renders only touch bytes already written
  logic [7:0] shadow [0:VRAM_BYTES-1];
  bit         known [0:VRAM_BYTES-1];
  cfg_t       setting;
  logic       no_gaps = 1'b0;
  int         phase_items;
  int         stall_cycles = 0;

  tile_background_pixel_fetch dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .request(request),
    .full(full),
    .pop(pop),
    .empty(empty),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  tile_fetch_checker pixel_check (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .request(request),
    .pop(pop),
    .empty(empty),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pixels_owed(pixels_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_item_t random_fields();
    in_item_t it;
    it.op = $urandom_range(0, 1);
    it.vram_addr = $urandom_range(0, VRAM_BYTES - 1);
    it.vram_data = $urandom_range(0, 255);
    it.pixel_x = $urandom_range(0, 255);
    it.screen_line = $urandom_range(0, 255);
    return it;
  endfunction

  function automatic cfg_t pick_setting(input int p);
    cfg_t c;
    c.scroll_x = $urandom_range(0, 255);
    c.scroll_y = $urandom_range(0, 255);
    c.bg_palette = $urandom_range(0, 255);
    c.map_select = $urandom_range(0, 1);
    c.data_select = $urandom_range(0, 1);
    c.bg_enable = ($urandom_range(0, 4) != 0);
    if (p == 0) begin
      c = '{scroll_x: 8'd0, scroll_y: 8'd0, bg_palette: 8'hE4, map_select: 1'b0,
            data_select: 1'b0, bg_enable: 1'b1};
    end else if (p == 1) begin
      c = '{scroll_x: 8'hFF, scroll_y: 8'hFF, bg_palette: 8'hFF, map_select: 1'b1,
            data_select: 1'b1, bg_enable: 1'b1};
    end else if (p == 2) begin
      c.bg_palette = 8'h00;
      c.map_select = 1'b0;
      c.data_select = 1'b1;
      c.bg_enable = 1'b0;
    end
    return c;
  endfunction

  // offer one item; push stays high across back-to-back transfers
  task automatic send(input in_item_t item);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= item;
    push <= 1'b1;
    do @(posedge clk); while (full);
    phase_items++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (pixels_owed != 0);
    // writes may still be in the work queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input cfg_t c);
    write_reg(CFG_SCROLL_X, c.scroll_x);
    write_reg(CFG_SCROLL_Y, c.scroll_y);
    write_reg(CFG_BG_PALETTE, c.bg_palette);
    write_reg(CFG_MAP_SELECT, {7'd0, c.map_select});
    write_reg(CFG_DATA_SELECT, {7'd0, c.data_select});
    write_reg(CFG_BG_ENABLE, {7'd0, c.bg_enable});
    cfg_valid <= 1'b0;
    setting = c;
  endtask

  task automatic write_byte(input logic [12:0] addr, input logic [7:0] value);
    in_item_t item;
    item = random_fields();
    item.op = OP_WRITE;
    item.vram_addr = addr;
    item.vram_data = value;
    send(item);
    shadow[addr] = value;
    known[addr] = 1'b1;
  endtask

  // write the byte if it is still blank, and now and then anyway
  task automatic prepare_byte(input logic [12:0] addr);
    if (!known[addr] || $urandom_range(0, 3) == 0) begin
      write_byte(addr, $urandom_range(0, 255));
    end
  endtask

  task automatic render_pixel(input logic [7:0] px, input logic [7:0] line);
    logic [7:0]  ax, ay, tile;
    logic [12:0] map_addr, row;
    in_item_t    item;
    ax = px + setting.scroll_x;
    ay = line + setting.scroll_y;
    map_addr = (setting.map_select ? MAP1_BASE : MAP0_BASE) + {3'd0, ay[7:3], ax[7:3]};
    prepare_byte(map_addr);
    tile = shadow[map_addr];
    if (setting.data_select) begin
      row = {1'b0, tile, 4'd0};
    end else begin
      row = SIGNED_TILE_BASE + {1'b0, tile ^ 8'h80, 4'd0};
    end
    row = row + {9'd0, ay[2:0], 1'b0};
    prepare_byte(row);
    prepare_byte(row + 13'd1);
    item = random_fields();
    item.op = OP_RENDER;
    item.pixel_x = px;
    item.screen_line = line;
    send(item);
  endtask

  task automatic render_off_screen(input logic [7:0] px, input logic [7:0] line);
    in_item_t item;
    item = random_fields();
    item.op = OP_RENDER;
    item.pixel_x = px;
    item.screen_line = line;
    send(item);
  endtask

  task automatic random_step();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      render_pixel($urandom_range(0, SCREEN_WIDTH_DEFAULT - 1),
                   $urandom_range(0, SCREEN_HEIGHT_DEFAULT - 1));
    end else if (kind < 9) begin
      write_byte($urandom_range(0, VRAM_BYTES - 1), $urandom_range(0, 255));
    end else if ($urandom_range(0, 1)) begin
      render_off_screen($urandom_range(SCREEN_WIDTH_DEFAULT, 255), $urandom_range(0, 255));
    end else begin
      render_off_screen($urandom_range(0, 255), $urandom_range(SCREEN_HEIGHT_DEFAULT, 255));
    end
  endtask

  initial begin : stimulus
    bit drained;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) wait_idle();
      apply_setting(pick_setting(p));
      no_gaps = (p == 3);
      phase_items = 0;
      drained = 1'b0;
      if (p == 0) begin
        write_byte(13'd0, 8'h00);
        write_byte(VRAM_BYTES - 1, 8'hFF);
        render_pixel(8'd0, 8'd0);
        render_pixel(SCREEN_WIDTH_DEFAULT - 1, SCREEN_HEIGHT_DEFAULT - 1);
        render_off_screen(SCREEN_WIDTH_DEFAULT, 8'd0);
        render_off_screen(8'd0, SCREEN_HEIGHT_DEFAULT);
        render_off_screen(8'hFF, 8'hFF);
      end
      while (phase_items < PHASE_ITEMS) begin
        // one mid-phase pause until every pixel has come back
        if (p == 5 && !drained && phase_items >= PHASE_ITEMS / 2) begin
          wait_idle();
          drained = 1'b1;
        end
        random_step();
      end
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_drain
    int gap;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      // long hold-off lets the work queue fill and full rise
      if (taken == 120 || taken == 450) gap = HOLD_CYCLES;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
    end
  end

endmodule

/* files.f */
+incdir+rtl
rtl/tbpf_pkg.sv
rtl/tbpf_front.sv
rtl/tbpf_queue.sv
rtl/tbpf_back.sv
rtl/tile_background_pixel_fetch.sv
verif/tile_fetch_checker.sv
verif/tb_tile_background_pixel_fetch.sv
